/* rtl/core/upst_pkg.sv */
// ----------------------------------------------------------------------------
// upst_pkg
// Types and constants shared by the UDP peer session table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package upst_pkg;

    // Field widths
    localparam int ID_W     = 5;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int NOW_W    = 48;
    localparam int PING_W   = 32;
    localparam int KIND_W   = 3;
    localparam int REPLY_W  = 2;
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 2;

    // Stream payload widths
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 8;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_MAX_PEERS   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_TIMEOUT     = 2'd1;
    localparam logic [CIDX_W-1:0] REG_PING_OFFSET = 2'd2;

    // Register reset values
    localparam logic [ID_W-1:0]  MAX_PEERS_RST   = 5'd16;
    localparam logic [CFG_W-1:0] TIMEOUT_RST     = 16'd5000;
    localparam logic [CFG_W-1:0] PING_OFFSET_RST = 16'd1000;

    // Input function codes
    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_SCAN   = 1'b1;

    // Packet kinds
    localparam logic [KIND_W-1:0] KIND_CONNECT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DISCONNECT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PING       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DATA       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOFREE     = 3'd5;

    // Reply kinds
    localparam logic [REPLY_W-1:0] REPLY_NONE   = 2'd0;
    localparam logic [REPLY_W-1:0] REPLY_ACK    = 2'd1;
    localparam logic [REPLY_W-1:0] REPLY_NOFREE = 2'd2;
    localparam logic [REPLY_W-1:0] REPLY_PING   = 2'd3;

    // Event kinds
    localparam logic EV_PACKET  = 1'b0;
    localparam logic EV_TIMEOUT = 1'b1;

    localparam logic [PING_W-1:0] PING_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DECIDE,
        ST_PING,
        ST_ALLOC,
        ST_UPDATE,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;       // take the input item
        logic rd;         // read the slot at the scan index
        logic idx_inc;    // advance the scan index
        logic pkt_check;  // record match, free slot and count for a packet
        logic scan_take;  // take an expired slot during a scan
        logic alloc;      // write the sender into the first free slot
        logic ping_diff;  // form now minus last seen
        logic update;     // refresh, clear or ping the chosen slot
        logic emit_pkt;   // load the packet verdict into the output
        logic emit_pend;  // load the pending event as the final one
    } cmd_t;

    typedef struct packed {
        logic new_func;
        logic func;
        logic lim_zero;
        logic last_idx;
        logic expired;
        logic pend_valid;
        logic out_free;
        logic refused;
        logic is_connect;
        logic ping_match;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/upst_ctrl.sv */
// ----------------------------------------------------------------------------
// upst_ctrl
// Sequencer for the session table: slot scan, allocation, update, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module upst_ctrl
    import upst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   take_ok;

    // a new event may be taken when no event is pending or the output frees
    assign take_ok = !st.pend_valid || st.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!st.lim_zero)
                    begin
                        state_next = ST_READ;
                    end
                    else if (st.new_func == FUNC_SCAN)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (st.func == FUNC_PACKET)
                begin
                    state_next = st.last_idx ? ST_DECIDE : ST_READ;
                end
                else if (!st.expired || take_ok)
                begin
                    state_next = st.last_idx ? ST_FLUSH : ST_READ;
                end
            end
            ST_DECIDE:
            begin
                priority if (st.refused)
                begin
                    state_next = ST_EMIT;
                end
                else if (st.is_connect)
                begin
                    state_next = ST_ALLOC;
                end
                else if (st.ping_match)
                begin
                    state_next = ST_PING;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_PING:
            begin
                state_next = ST_UPDATE;
            end
            ST_ALLOC:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (!st.pend_valid || st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_CHECK:
            begin
                if (st.func == FUNC_PACKET)
                begin
                    cmd.pkt_check = 1'b1;
                    cmd.idx_inc   = !st.last_idx;
                end
                else if (!st.expired || take_ok)
                begin
                    cmd.scan_take = st.expired;
                    cmd.idx_inc   = !st.last_idx;
                end
            end
            ST_PING:
            begin
                cmd.ping_diff = 1'b1;
            end
            ST_ALLOC:
            begin
                cmd.alloc = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_pkt = st.out_free;
            end
            ST_FLUSH:
            begin
                cmd.emit_pend = st.pend_valid && st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/upst_dp.sv */
// ----------------------------------------------------------------------------
// upst_dp
// Session table datapath: registers, slot memories, compare and time math,
// pending timeout event and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module upst_dp
    import upst_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CIDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast,
    output logic [OUT_USER_W-1:0]      m_tuser,
    input  wire cmd_t                  cmd,
    output status_t                    st
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [TIME_BITS-1:0] stime_t;

    // configuration
    logic [ID_W-1:0]  max_peers_reg;
    logic [CFG_W-1:0] timeout_reg;
    logic [CFG_W-1:0] offset_reg;
    logic [ID_W-1:0]  lim;

    // item
    logic              func_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_in;
    logic [ADDR_W-1:0] src_addr_reg;
    logic [PORT_W-1:0] src_port_reg;
    stime_t            now_reg;

    // slot memories and valid bits
    logic [ADDR_W-1:0] mem_addr [SLOTS];
    logic [PORT_W-1:0] mem_port [SLOTS];
    stime_t            mem_time [SLOTS];
    logic [PING_W-1:0] mem_ping [SLOTS];
    logic [SLOTS-1:0]  used_reg;
    logic [SLOTS-1:0]  pvalid_reg;

    logic [ID_W-1:0]   idx_reg;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [PORT_W-1:0] rd_port_reg;
    stime_t            rd_time_reg;
    logic [PING_W-1:0] rd_ping_reg;
    logic              rd_used_reg;
    logic              rd_pvalid_reg;
    logic [PING_W-1:0] rd_ping;

    // packet scan results
    logic              cid_found_reg;
    logic [ID_W-1:0]   cid_idx_reg;
    logic [PING_W-1:0] cid_ping_reg;
    stime_t            match_time_reg;
    logic              free_found_reg;
    logic [ID_W-1:0]   free_idx_reg;
    logic [PING_W-1:0] free_ping_reg;
    logic [ID_W-1:0]   active_reg;

    // ping math
    stime_t            diff_reg;
    logic              diff_ok_reg;
    logic [TIME_BITS:0] ping_sub;
    stime_t            ping_val;
    logic [PING_W-1:0] ping_sat;

    // scan events
    logic [TIME_BITS:0] age_sub;
    logic              expired;
    logic              pend_valid_reg;
    logic [ID_W-1:0]   pend_idx_reg;
    logic [PING_W-1:0] pend_ping_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [PORT_W-1:0] pend_port_reg;

    // write controls
    logic              hit;
    logic              clear_kind;
    logic              refused;
    logic              time_we;
    logic [IDX_W-1:0]  time_wa;
    logic              ping_we;
    logic [IDX_W-1:0]  cid_wa;
    logic [IDX_W-1:0]  free_wa;

    // output register
    logic              out_free;
    logic              out_load;
    logic              out_valid_reg;
    logic              ek_next, ek_reg;
    logic              cv_next, cv_reg;
    logic [ID_W-1:0]   cid_next, cid_reg;
    logic [REPLY_W-1:0] rk_next, rk_reg;
    logic [KIND_W-1:0] dk_next, dk_reg;
    logic              pv_next, pv_reg;
    logic [PING_W-1:0] ping_next, ping_reg;
    logic [ADDR_W-1:0] paddr_next, paddr_reg;
    logic [PORT_W-1:0] pport_next, pport_reg;
    logic              last_next, last_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_peers_reg <= MAX_PEERS_RST;
            timeout_reg   <= TIMEOUT_RST;
            offset_reg    <= PING_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_PEERS:   max_peers_reg <= cfg_data[ID_W-1:0];
                REG_TIMEOUT:     timeout_reg   <= cfg_data;
                REG_PING_OFFSET: offset_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign lim = (32'(max_peers_reg) > 32'(SLOTS)) ? ID_W'(SLOTS) : max_peers_reg;

    // ---------------- item capture ----------------
    assign kind_in = (s_tuser[3:1] > KIND_DATA) ? KIND_DATA : s_tuser[3:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg <= FUNC_PACKET;
            idx_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                func_reg <= s_tuser[0];
                idx_reg  <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + ID_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= kind_in;
            src_addr_reg <= s_tdata[31:0];
            src_port_reg <= s_tdata[47:32];
            now_reg      <= TIME_BITS'(s_tdata[95:48]);
        end
    end

    // ---------------- slot memories ----------------
    assign rd_idx  = IDX_W'(idx_reg);
    assign cid_wa  = IDX_W'(cid_idx_reg);
    assign free_wa = IDX_W'(free_idx_reg);

    assign clear_kind = (kind_reg == KIND_DISCONNECT) || (kind_reg == KIND_TIMEOUT);
    assign ping_we    = cmd.update && cid_found_reg && (kind_reg == KIND_PING);

    always_comb
    begin
        time_we = 1'b0;
        time_wa = '0;
        priority if (cmd.alloc)
        begin
            time_we = 1'b1;
            time_wa = free_wa;
        end
        else if (cmd.update && cid_found_reg && !clear_kind)
        begin
            time_we = 1'b1;
            time_wa = cid_wa;
        end
        else if (cmd.scan_take)
        begin
            time_we = 1'b1;
            time_wa = rd_idx;
        end
        else
        begin
            time_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            mem_addr[free_wa] <= src_addr_reg;
        end
        if (cmd.rd)
        begin
            rd_addr_reg <= mem_addr[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            mem_port[free_wa] <= src_port_reg;
        end
        if (cmd.rd)
        begin
            rd_port_reg <= mem_port[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (time_we)
        begin
            mem_time[time_wa] <= now_reg;
        end
        if (cmd.rd)
        begin
            rd_time_reg <= mem_time[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ping_we)
        begin
            mem_ping[cid_wa] <= ping_sat;
        end
        if (cmd.rd)
        begin
            rd_ping_reg <= mem_ping[rd_idx];
        end
    end

    // slots never written read as unused with zero ping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            pvalid_reg    <= '0;
            rd_used_reg   <= 1'b0;
            rd_pvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                used_reg[free_wa] <= 1'b1;
            end
            if (cmd.update && cid_found_reg && clear_kind)
            begin
                used_reg[cid_wa] <= 1'b0;
            end
            if (ping_we)
            begin
                pvalid_reg[cid_wa] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_used_reg   <= used_reg[rd_idx];
                rd_pvalid_reg <= pvalid_reg[rd_idx];
            end
        end
    end

    assign rd_ping = rd_pvalid_reg ? rd_ping_reg : '0;
    assign hit     = rd_used_reg && (rd_addr_reg == src_addr_reg)
                     && (rd_port_reg == src_port_reg);

    // expired: time went forward and the idle span exceeds the timeout
    assign age_sub = {1'b0, now_reg} - {1'b0, rd_time_reg};
    assign expired = rd_used_reg && !age_sub[TIME_BITS]
                     && (age_sub[TIME_BITS-1:0] > TIME_BITS'(timeout_reg));

    // ---------------- packet scan and update ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cid_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cid_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                active_reg     <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.pkt_check)
            begin
                if (rd_used_reg)
                begin
                    active_reg <= active_reg + ID_W'(1);
                end
                if (hit)
                begin
                    cid_found_reg <= 1'b1;
                end
                if (!rd_used_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.alloc)
            begin
                cid_found_reg <= 1'b1;
            end
            if (cmd.scan_take)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.emit_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pkt_check)
        begin
            if (hit && !cid_found_reg)
            begin
                cid_idx_reg    <= idx_reg;
                cid_ping_reg   <= rd_ping;
                match_time_reg <= rd_time_reg;
            end
            if (!rd_used_reg && !free_found_reg)
            begin
                free_idx_reg  <= idx_reg;
                free_ping_reg <= rd_ping;
            end
        end
        // an earlier match keeps the client id; else the new slot takes it
        if (cmd.alloc && !(cid_found_reg && (cid_idx_reg < free_idx_reg)))
        begin
            cid_idx_reg  <= free_idx_reg;
            cid_ping_reg <= free_ping_reg;
        end
        if (cmd.ping_diff)
        begin
            {diff_ok_reg, diff_reg} <= {1'b0, now_reg} - {1'b0, match_time_reg};
        end
        if (ping_we)
        begin
            cid_ping_reg <= ping_sat;
        end
        if (cmd.scan_take)
        begin
            pend_idx_reg  <= idx_reg;
            pend_ping_reg <= rd_ping;
            pend_addr_reg <= rd_addr_reg;
            pend_port_reg <= rd_port_reg;
        end
    end

    // diff_ok_reg holds the borrow; zero borrow means time moved forward
    assign ping_sub = {1'b0, diff_reg} - {1'b0, TIME_BITS'(offset_reg)};
    assign ping_val = (!diff_ok_reg && (diff_reg > TIME_BITS'(offset_reg)))
                      ? ping_sub[TIME_BITS-1:0] : '0;
    assign ping_sat = (ping_val > TIME_BITS'(PING_MAX)) ? PING_MAX
                      : ping_val[PING_W-1:0];

    assign refused = (kind_reg == KIND_CONNECT) && (active_reg >= lim);

    // ---------------- output register ----------------
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = cmd.emit_pkt || cmd.emit_pend || (cmd.scan_take && pend_valid_reg);

    always_comb
    begin
        ek_next    = EV_TIMEOUT;
        cv_next    = 1'b1;
        cid_next   = pend_idx_reg;
        rk_next    = REPLY_NONE;
        dk_next    = KIND_TIMEOUT;
        pv_next    = 1'b0;
        ping_next  = pend_ping_reg;
        paddr_next = pend_addr_reg;
        pport_next = pend_port_reg;
        last_next  = cmd.emit_pend;
        if (cmd.emit_pkt)
        begin
            ek_next    = EV_PACKET;
            paddr_next = '0;
            pport_next = '0;
            last_next  = 1'b1;
            priority if (refused)
            begin
                cv_next   = 1'b1;
                cid_next  = active_reg;
                rk_next   = REPLY_NOFREE;
                dk_next   = KIND_NOFREE;
                pv_next   = 1'b0;
                ping_next = '0;
            end
            else if (cid_found_reg)
            begin
                cv_next   = 1'b1;
                cid_next  = cid_idx_reg;
                dk_next   = kind_reg;
                pv_next   = 1'b0;
                ping_next = cid_ping_reg;
                if (kind_reg == KIND_CONNECT)
                begin
                    rk_next = REPLY_ACK;
                end
                else if (kind_reg == KIND_PING)
                begin
                    rk_next = REPLY_PING;
                end
                else
                begin
                    rk_next = REPLY_NONE;
                end
            end
            else
            begin
                cv_next   = 1'b0;
                cid_next  = '0;
                rk_next   = REPLY_NONE;
                dk_next   = kind_reg;
                pv_next   = 1'b1;
                ping_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ek_reg    <= ek_next;
            cv_reg    <= cv_next;
            cid_reg   <= cid_next;
            rk_reg    <= rk_next;
            dk_reg    <= dk_next;
            pv_reg    <= pv_next;
            ping_reg  <= ping_next;
            paddr_reg <= paddr_next;
            pport_reg <= pport_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, pport_reg, paddr_reg, ping_reg, cid_reg};
    assign m_tuser  = {pv_reg, dk_reg, rk_reg, cv_reg, ek_reg};

    // ---------------- status ----------------
    assign st.new_func   = s_tuser[0];
    assign st.func       = func_reg;
    assign st.lim_zero   = (lim == '0);
    assign st.last_idx   = (idx_reg == lim - ID_W'(1));
    assign st.expired    = expired;
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;
    assign st.refused    = refused;
    assign st.is_connect = (kind_reg == KIND_CONNECT);
    assign st.ping_match = (kind_reg == KIND_PING) && cid_found_reg;

endmodule

`default_nettype wire

/* rtl/core/udp_peer_session_table.sv */
// ----------------------------------------------------------------------------
// udp_peer_session_table
// Peer slot table keyed by IPv4 address and UDP port: connect, disconnect,
// ping and timeout handling per packet, and timeout scans over the first L slots.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   packet or scan request
// m_*       out  m_tvalid/m_tready   packet verdict or timeout event (m_tlast)
// cfg_*     in   cfg_we              register write, no read-back
//
// L = min(max_peers, SLOTS); each slot costs one memory read and one compare.
// A packet walks the slots, then DECIDE, then PING (matched ping) or ALLOC
// (connect), then UPDATE and EMIT; a refused connect goes from DECIDE to EMIT.
// A scan walks the slots, then FLUSH. Output stalls can hold CHECK, EMIT, FLUSH.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted. Reset clears the valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_peer_session_table
    import upst_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // write port
    input  wire logic                  cfg_we,
    input  wire logic [CIDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // src_addr, src_port, now_ms
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // func, packet_kind
    // output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // client_id, ping_ms, peer_addr,
                                                  // peer_port, zero pad
    output logic                       m_tlast,
    output logic [OUT_USER_W-1:0]      m_tuser    // event_kind, client_valid,
                                                  // reply_kind, delivered_kind,
                                                  // payload_void
);

    cmd_t    cmd;
    status_t st;

    upst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    upst_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

/* rtl/core/upst_chk.sv */
// ----------------------------------------------------------------------------
// upst_chk
// Port-level checks for the session table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module upst_chk
    import upst_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tlast,
    input wire logic [OUT_USER_W-1:0] m_tuser
);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready
    ) else $error("input accepted while an item is in work");

    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast)
    ) else $error("stalled result changed");

    a_verdict_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == EV_PACKET) |-> m_tlast
    ) else $error("packet verdict not marked last");

    a_void_no_client: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[7] |-> !m_tuser[1] && (m_tdata[4:0] == '0)
                                   && (m_tuser[0] == EV_PACKET)
    ) else $error("void verdict carries a client");

    a_event_fields: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == EV_TIMEOUT) |-> m_tuser[1]
            && (m_tuser[6:4] == KIND_TIMEOUT) && (m_tuser[3:2] == REPLY_NONE)
    ) else $error("malformed timeout event");

endmodule

bind udp_peer_session_table upst_chk u_upst_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UDP peer session table. Drives packet and scan
// items in bursts against a stalling receiver, and predicts each verdict and
// timeout event from a local copy of the slot table. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------

import upst_pkg::*;

typedef struct {
    logic               event_kind;
    logic               client_valid;
    logic [ID_W-1:0]    client_id;
    logic [REPLY_W-1:0] reply_kind;
    logic [KIND_W-1:0]  delivered_kind;
    logic               payload_void;
    logic [PING_W-1:0]  ping_ms;
    logic [ADDR_W-1:0]  peer_addr;
    logic [PORT_W-1:0]  peer_port;
    logic               last;
} verdict_t;

class session_table_scoreboard;
    localparam int NUM_SLOTS = 16;

    logic [ADDR_W-1:0] addr_tab [NUM_SLOTS];
    logic [PORT_W-1:0] port_tab [NUM_SLOTS];
    logic              used_tab [NUM_SLOTS];
    logic [NOW_W-1:0]  seen_tab [NUM_SLOTS];
    logic [PING_W-1:0] ping_tab [NUM_SLOTS];

    logic [ID_W-1:0]   max_peers = MAX_PEERS_RST;
    logic [CFG_W-1:0]  timeout_ms = TIMEOUT_RST;
    logic [CFG_W-1:0]  ping_offset_ms = PING_OFFSET_RST;

    verdict_t verdicts_due [$];
    int errors = 0;
    int checked = 0;

    function void clear_table();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            addr_tab[i] = '0;
            port_tab[i] = '0;
            used_tab[i] = 1'b0;
            seen_tab[i] = '0;
            ping_tab[i] = '0;
        end
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_MAX_PEERS:   max_peers = val[ID_W-1:0];
            REG_TIMEOUT:     timeout_ms = val;
            REG_PING_OFFSET: ping_offset_ms = val;
            default: ;
        endcase
    endfunction

    function int slot_limit();
        return (max_peers > NUM_SLOTS) ? NUM_SLOTS : int'(max_peers);
    endfunction

    function int find_peer(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p);
        int lim;
        lim = slot_limit();
        for (int i = 0; i < lim; i++)
            if (used_tab[i] && addr_tab[i] == a && port_tab[i] == p)
                return i;
        return -1;
    endfunction

    // append one expected result at the tail
    function void queue_verdict(verdict_t v);
        verdicts_due.insert(verdicts_due.size(), v);
    endfunction

    function verdict_t compose(logic ek, logic cv, logic [ID_W-1:0] cid,
                               logic [REPLY_W-1:0] rk, logic [KIND_W-1:0] dk,
                               logic pv, logic [PING_W-1:0] pg,
                               logic [ADDR_W-1:0] pa, logic [PORT_W-1:0] pp,
                               logic lst);
        verdict_t v;
        v.event_kind = ek;
        v.client_valid = cv;
        v.client_id = cid;
        v.reply_kind = rk;
        v.delivered_kind = dk;
        v.payload_void = pv;
        v.ping_ms = pg;
        v.peer_addr = pa;
        v.peer_port = pp;
        v.last = lst;
        return v;
    endfunction

    // Work out the verdict or the timeout events of one accepted item.
    function void take_request(logic [IN_USER_W-1:0] user, logic [IN_DATA_W-1:0] data);
        logic               func;
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  a;
        logic [PORT_W-1:0]  p;
        logic [NOW_W-1:0]   now;
        logic [NOW_W-1:0]   span;
        logic [REPLY_W-1:0] reply;
        verdict_t           v;
        int                 lim;
        int                 cid;
        int                 active;
        int                 first;

        func = user[0];
        kind = user[3:1];
        a = data[31:0];
        p = data[47:32];
        now = data[95:48];
        lim = slot_limit();

        if (func == FUNC_SCAN)
        begin
            first = verdicts_due.size();
            for (int i = 0; i < lim; i++)
            begin
                if (used_tab[i] && now > seen_tab[i]
                    && (now - seen_tab[i]) > NOW_W'(timeout_ms))
                begin
                    queue_verdict(compose(EV_TIMEOUT, 1'b1, ID_W'(i), REPLY_NONE,
                                          KIND_TIMEOUT, 1'b0, ping_tab[i],
                                          addr_tab[i], port_tab[i], 1'b0));
                    seen_tab[i] = now;
                end
            end
            // mark the final event of the scan
            if (verdicts_due.size() > first)
            begin
                v = verdicts_due[verdicts_due.size() - 1];
                v.last = 1'b1;
                verdicts_due[verdicts_due.size() - 1] = v;
            end
            return;
        end

        if (kind > KIND_DATA)
            kind = KIND_DATA;
        cid = find_peer(a, p);
        reply = REPLY_NONE;

        if (kind == KIND_CONNECT)
        begin
            active = 0;
            for (int i = 0; i < lim; i++)
                if (used_tab[i])
                    active++;
            if (active >= lim)
            begin
                queue_verdict(compose(EV_PACKET, 1'b1, ID_W'(active), REPLY_NOFREE,
                                      KIND_NOFREE, 1'b0, '0, '0, '0, 1'b1));
                return;
            end
            reply = REPLY_ACK;
            for (int i = 0; i < lim; i++)
            begin
                if (!used_tab[i])
                begin
                    addr_tab[i] = a;
                    port_tab[i] = p;
                    seen_tab[i] = now;
                    used_tab[i] = 1'b1;
                    break;
                end
            end
            // an earlier slot wins if the sender was already connected
            cid = find_peer(a, p);
        end
        else if (kind == KIND_DISCONNECT || kind == KIND_TIMEOUT)
        begin
            if (cid >= 0)
            begin
                addr_tab[cid] = '0;
                port_tab[cid] = '0;
                seen_tab[cid] = '0;
                used_tab[cid] = 1'b0;
            end
        end
        else if (kind == KIND_PING && cid >= 0)
        begin
            reply = REPLY_PING;
            span = '0;
            if (now > seen_tab[cid] && (now - seen_tab[cid]) > NOW_W'(ping_offset_ms))
                span = now - seen_tab[cid] - NOW_W'(ping_offset_ms);
            ping_tab[cid] = (span > NOW_W'(PING_MAX)) ? PING_MAX : span[PING_W-1:0];
        end

        if (cid >= 0 && used_tab[cid])
            seen_tab[cid] = now;

        if (cid < 0)
            queue_verdict(compose(EV_PACKET, 1'b0, '0, reply, kind, 1'b1,
                                  '0, '0, '0, 1'b1));
        else
            queue_verdict(compose(EV_PACKET, 1'b1, ID_W'(cid), reply, kind, 1'b0,
                                  ping_tab[cid], '0, '0, 1'b1));
    endfunction

    task report(string what);
        errors++;
        $display("ERROR: %s", what);
    endtask

    task diff(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                             checked, field, got, want));
    endtask

    task check_verdict(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user, logic lst);
        verdict_t got;
        verdict_t want;

        got.event_kind = user[0];
        got.client_valid = user[1];
        got.reply_kind = user[3:2];
        got.delivered_kind = user[6:4];
        got.payload_void = user[7];
        got.client_id = data[4:0];
        got.ping_ms = data[36:5];
        got.peer_addr = data[68:37];
        got.peer_port = data[84:69];
        got.last = lst;
        checked++;
        if (verdicts_due.size() == 0)
        begin
            report($sformatf("result %0d arrived with nothing outstanding", checked));
            return;
        end
        want = verdicts_due.pop_front();
        diff("event_kind", 64'(got.event_kind), 64'(want.event_kind));
        diff("client_valid", 64'(got.client_valid), 64'(want.client_valid));
        diff("client_id", 64'(got.client_id), 64'(want.client_id));
        diff("reply_kind", 64'(got.reply_kind), 64'(want.reply_kind));
        diff("delivered_kind", 64'(got.delivered_kind), 64'(want.delivered_kind));
        diff("payload_void", 64'(got.payload_void), 64'(want.payload_void));
        diff("ping_ms", 64'(got.ping_ms), 64'(want.ping_ms));
        diff("peer_addr", 64'(got.peer_addr), 64'(want.peer_addr));
        diff("peer_port", 64'(got.peer_port), 64'(want.peer_port));
        diff("last", 64'(got.last), 64'(want.last));
    endtask
endclass

module tb;
    localparam int IDLE_GAP    = 60;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL        = 12;

    typedef enum {RX_OPEN, RX_COIN, RX_NOTCH, RX_SLOW} rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CIDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // src_addr, src_port, now_ms
    logic [IN_USER_W-1:0]  s_tuser = '0;   // func, packet_kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // client_id, ping_ms, peer_addr, peer_port, pad
    logic                  m_tlast;
    logic [OUT_USER_W-1:0] m_tuser;        // event_kind, client_valid, reply_kind,
                                           // delivered_kind, payload_void

    session_table_scoreboard sb;
    int          burst_left = 0;
    int          cycle_count = 0;
    int          ready_hold = 0;
    rx_mode_t    ready_mode = RX_OPEN;
    logic [47:0] now_ms = '0;
    logic [31:0] pool_addr [POOL];
    logic [15:0] pool_port [POOL];

    udp_peer_session_table uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: switch between stall patterns every so often
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode <= rx_mode_t'($urandom_range(0, 3));
            ready_hold <= $urandom_range(20, 200);
        end
        else
            ready_hold <= ready_hold - 1;
        case (ready_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= ($urandom_range(0, 1) == 1);
            RX_NOTCH: m_tready <= (cycle_count % 8 != 3);
            default:  m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_verdict(m_tdata, m_tuser, m_tlast);
        end
    end

    task send_item(input logic func, input logic [KIND_W-1:0] kind,
                   input logic [31:0] a, input logic [15:0] p, input logic [47:0] t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t, p, a};
        s_tuser <= {kind, func};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    // hold the sender until every outstanding result has arrived
    task wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task configure(input logic [CFG_W-1:0] peers, input logic [CFG_W-1:0] idle_limit,
                   input logic [CFG_W-1:0] offset);
        wait_drained();
        // a scan with no events may still be walking the slots
        repeat (IDLE_GAP) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_MAX_PEERS;
        cfg_data <= peers;
        @(posedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_data <= idle_limit;
        @(posedge clk);
        cfg_index <= REG_PING_OFFSET;
        cfg_data <= offset;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(REG_MAX_PEERS, peers);
        sb.set_reg(REG_TIMEOUT, idle_limit);
        sb.set_reg(REG_PING_OFFSET, offset);
    endtask

    task random_items(input int count);
        int                pick;
        int                who;
        logic [31:0]       a;
        logic [15:0]       p;
        logic [KIND_W-1:0] kind;
        logic              func;

        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                now_ms = now_ms + 48'($urandom_range(0, 1500));
            else if (pick < 88)
                now_ms = now_ms + 48'($urandom_range(1000, 70000));
            else if (pick < 93)
                now_ms = now_ms - 48'($urandom_range(0, 3000));
            else if (pick < 97)
                now_ms = now_ms + (48'($urandom_range(1, 255)) << 32);
            else
                now_ms = {16'($urandom), 32'($urandom)};

            who = $urandom_range(0, POOL - 1);
            a = pool_addr[who];
            p = pool_port[who];
            pick = $urandom_range(0, 99);
            if (pick < 10)
                a = $urandom;
            else if (pick < 15)
                p = p ^ 16'($urandom_range(1, 65535));

            func = ($urandom_range(0, 99) < 12) ? FUNC_SCAN : FUNC_PACKET;
            pick = $urandom_range(0, 99);
            if (pick < 22)
                kind = KIND_CONNECT;
            else if (pick < 32)
                kind = KIND_DISCONNECT;
            else if (pick < 57)
                kind = KIND_PING;
            else if (pick < 64)
                kind = KIND_TIMEOUT;
            else if (pick < 94)
                kind = KIND_DATA;
            else
                kind = KIND_NOFREE + KIND_W'($urandom_range(0, 2));

            send_item(func, kind, a, p, now_ms);
            if ($urandom_range(0, 59) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        sb = new;
        sb.clear_table();
        for (int i = 0; i < POOL; i++)
        begin
            pool_addr[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end
        pool_addr[0] = '1;
        pool_port[0] = '1;
        pool_addr[1] = '0;
        pool_port[1] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 16 slots, timeout 5000, ping offset 1000
        send_item(FUNC_PACKET, KIND_DATA, pool_addr[2], pool_port[2], 48'd0);
        send_item(FUNC_PACKET, KIND_CONNECT, pool_addr[2], pool_port[2], 48'd100);
        // second connect of the same peer takes a new slot, reports the first
        send_item(FUNC_PACKET, KIND_CONNECT, pool_addr[2], pool_port[2], 48'd200);
        send_item(FUNC_PACKET, KIND_PING, pool_addr[2], pool_port[2], 48'd1500);
        send_item(FUNC_PACKET, KIND_PING, pool_addr[2], pool_port[2], 48'd1600);
        send_item(FUNC_PACKET, KIND_PING, pool_addr[2], pool_port[2], 48'd1000);
        send_item(FUNC_PACKET, KIND_NOFREE, pool_addr[2], pool_port[2], 48'd1700);
        send_item(FUNC_PACKET, '1, pool_addr[0], pool_port[0], 48'd1800);
        send_item(FUNC_PACKET, KIND_CONNECT, pool_addr[0], pool_port[0], 48'd2000);
        send_item(FUNC_PACKET, KIND_CONNECT, pool_addr[1], pool_port[1], 48'd2100);
        // idle time beyond 32 bits saturates the ping
        send_item(FUNC_PACKET, KIND_PING, pool_addr[0], pool_port[0], 48'd2000 + (48'd1 << 33));
        send_item(FUNC_PACKET, KIND_DISCONNECT, pool_addr[2], pool_port[2], 48'd3000);
        send_item(FUNC_PACKET, KIND_TIMEOUT, pool_addr[2], pool_port[2], 48'd3100);
        send_item(FUNC_PACKET, KIND_DISCONNECT, pool_addr[2], pool_port[2], 48'd3200);
        send_item(FUNC_SCAN, KIND_DATA, '0, '0, '1);
        send_item(FUNC_SCAN, KIND_DATA, '0, '0, '1);
        send_item(FUNC_SCAN, KIND_DATA, '0, '0, 48'd5);
        send_item(FUNC_PACKET, KIND_PING, pool_addr[1], pool_port[1], '1);
        send_item(FUNC_PACKET, KIND_TIMEOUT, pool_addr[1], pool_port[1], '1);

        // two visible slots; stray upper data bits must be ignored
        configure(16'hFFE2, '0, '0);
        send_item(FUNC_PACKET, KIND_CONNECT, pool_addr[3], pool_port[3], 48'd4000);
        send_item(FUNC_PACKET, KIND_CONNECT, pool_addr[4], pool_port[4], 48'd4000);
        send_item(FUNC_PACKET, KIND_CONNECT, pool_addr[5], pool_port[5], 48'd4000);

        // no visible slots: every connect refused with index zero
        configure('0, '0, '0);
        send_item(FUNC_PACKET, KIND_CONNECT, pool_addr[3], pool_port[3], 48'd5000);
        send_item(FUNC_SCAN, KIND_DATA, '0, '0, 48'd90000);
        send_item(FUNC_PACKET, KIND_PING, pool_addr[0], pool_port[0], 48'd90000);

        // limit above the slot count clamps; fill every slot, then expire all
        configure(16'd31, '1, '1);
        now_ms = 48'd100000;
        send_item(FUNC_PACKET, KIND_DISCONNECT, pool_addr[0], pool_port[0], now_ms);
        for (int i = 0; i < 16; i++)
            send_item(FUNC_PACKET, KIND_CONNECT, $urandom, 16'($urandom), now_ms);
        now_ms = now_ms + 48'd100000;
        send_item(FUNC_SCAN, KIND_DATA, '0, '0, now_ms);
        random_items(40);

        configure(16'd16, TIMEOUT_RST, PING_OFFSET_RST);
        random_items(90);
        configure(16'd4, '0, '0);
        random_items(80);
        configure(16'd31, '1, '1);
        random_items(60);
        configure(16'd1, 16'($urandom), 16'($urandom));
        random_items(60);
        configure(16'd9, 16'd200, 16'd50);
        random_items(90);

        wait_drained();
        repeat (IDLE_GAP) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/upst_pkg.sv
rtl/core/upst_ctrl.sv
rtl/core/upst_dp.sv
rtl/core/udp_peer_session_table.sv
rtl/core/upst_chk.sv
sim/tb.sv
